// File: hw/rtl/pgbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgbe_pkg
// Shared constants, codes and word types of the packed glyph bitmap expander.
// ----------------------------------------------------------------------------
package pgbe_pkg;

  localparam int COORD_BITS    = 16;
  localparam int COLOR_BITS    = 16;
  localparam int OUTC_BITS     = COORD_BITS + 1;
  localparam int BG_BITS       = COLOR_BITS + 1;
  localparam int DIM_BITS      = 8;
  localparam int AREA_BITS     = 2 * DIM_BITS;
  localparam int BYTE_BITS     = 8;
  localparam int BIT_IDX_BITS  = $clog2(BYTE_BITS);
  localparam int CFG_IDX_BITS  = 1;

  localparam int ITEM_Q_DEPTH  = 2;
  localparam int ITEM_PTR_BITS = $clog2(ITEM_Q_DEPTH);
  localparam int ITEM_CNT_BITS = $clog2(ITEM_Q_DEPTH + 1);
  localparam int PIX_Q_DEPTH   = 2;
  localparam int PIX_PTR_BITS  = $clog2(PIX_Q_DEPTH);
  localparam int PIX_CNT_BITS  = $clog2(PIX_Q_DEPTH + 1);

  typedef enum logic [0:0] {
    ACT_BEGIN = 1'b0,
    ACT_BYTE  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FOREGROUND = 1'b0,
    CFG_BACKGROUND = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                         is_begin;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic [DIM_BITS-1:0]          width;
    logic [AREA_BITS-1:0]         area;
    logic [BYTE_BITS-1:0]         bits;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_head_t;

  typedef struct packed {
    logic signed [OUTC_BITS-1:0] x;
    logic signed [OUTC_BITS-1:0] y;
    logic [COLOR_BITS-1:0]       color;
    logic                        glyph_end;
    logic                        last_of_run;
  } pix_t;

endpackage
`default_nettype wire

// File: hw/rtl/pgbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgbe_front
// Input side: takes words, sorts begin from byte words, precomputes the glyph
// pixel count and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pgbe_front
  import pgbe_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic                         in_action,
  input  wire logic signed [COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [COORD_BITS-1:0] in_origin_y,
  input  wire logic [DIM_BITS-1:0]          in_glyph_width,
  input  wire logic [DIM_BITS-1:0]          in_glyph_height,
  input  wire logic [BYTE_BITS-1:0]         in_bitmap_byte,
  input  wire logic                         item_pop,
  output      item_head_t                   head
);

  item_t                    mem_r [ITEM_Q_DEPTH];
  logic [ITEM_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ITEM_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ITEM_CNT_BITS-1:0] cnt_r, cnt_nxt;
  item_t                    new_item;
  logic                     wr_en;
  logic                     rd_en;

  always_comb begin
    new_item          = '0;
    new_item.is_begin = (in_action == ACT_BEGIN);
    new_item.origin_x = in_origin_x;
    new_item.origin_y = in_origin_y;
    new_item.width    = in_glyph_width;
    new_item.area     = AREA_BITS'(in_glyph_width * in_glyph_height);
    new_item.bits     = in_bitmap_byte;
  end

  assign full  = (cnt_r == ITEM_CNT_BITS'(ITEM_Q_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = item_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: hw/rtl/pgbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgbe_back
// Pixel engine: holds glyph origin, size and counters, walks one bitmap bit
// per cycle unless a pixel waits on a full result queue, and produces pixel
// words; also owns the color registers.
module pgbe_back
  import pgbe_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [BG_BITS-1:0]      cfg_data,
  input  wire item_head_t              head,
  output      logic                    item_pop,
  input  wire logic                    pix_full,
  output      logic                    pix_push,
  output      pix_t                    pix
);

  logic [COLOR_BITS-1:0]   fg_r;
  logic [BG_BITS-1:0]      bg_r;
  logic [COORD_BITS-1:0]   base_x_r, base_x_nxt;
  logic [COORD_BITS-1:0]   base_y_r, base_y_nxt;
  logic [DIM_BITS-1:0]     width_r, width_nxt;
  logic [DIM_BITS-1:0]     col_r, col_nxt;
  logic [DIM_BITS-1:0]     row_r, row_nxt;
  logic [AREA_BITS-1:0]    left_r, left_nxt;
  logic [BIT_IDX_BITS-1:0] bit_r, bit_nxt;

  logic                    transp;
  logic                    in_glyph;
  logic [BIT_IDX_BITS-1:0] bit_sel;
  logic                    cur_set;
  logic                    emit;
  logic                    done;
  logic                    is_byte;
  logic                    is_begin;
  logic                    step;
  logic [BYTE_BITS-1:0]    later;

  assign transp   = &bg_r;
  assign in_glyph = (left_r != '0);
  assign bit_sel  = BIT_IDX_BITS'(BYTE_BITS - 1) - bit_r;
  assign cur_set  = head.item.bits[bit_sel];
  assign emit     = in_glyph && (cur_set || !transp);
  assign done     = (bit_r == BIT_IDX_BITS'(BYTE_BITS - 1)) || (left_r <= AREA_BITS'(1));
  assign is_byte  = head.valid && !head.item.is_begin;
  assign is_begin = head.valid && head.item.is_begin;
  assign step     = is_byte && !(emit && pix_full);
  assign item_pop = is_begin || (step && done);
  assign pix_push = is_byte && emit && !pix_full;

  // later bits of this byte that still land inside the glyph and get written
  always_comb begin
    for (int j = 0; j < BYTE_BITS; j++) begin
      later[j] = (BIT_IDX_BITS'(j) > bit_r)
              && (left_r > AREA_BITS'(BIT_IDX_BITS'(j) - bit_r))
              && (head.item.bits[BYTE_BITS-1-j] || !transp);
    end
  end

  always_comb begin
    pix.x           = {base_x_r[COORD_BITS-1], base_x_r}
                    + {{(OUTC_BITS-DIM_BITS){1'b0}}, col_r};
    pix.y           = {base_y_r[COORD_BITS-1], base_y_r}
                    + {{(OUTC_BITS-DIM_BITS){1'b0}}, row_r};
    pix.color       = cur_set ? fg_r : bg_r[COLOR_BITS-1:0];
    pix.glyph_end   = (left_r == AREA_BITS'(1));
    pix.last_of_run = ~|later;
  end

  always_comb begin
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    width_nxt  = width_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    left_nxt   = left_r;
    bit_nxt    = bit_r;
    if (is_begin) begin
      base_x_nxt = head.item.origin_x;
      base_y_nxt = head.item.origin_y;
      width_nxt  = head.item.width;
      col_nxt    = '0;
      row_nxt    = '0;
      left_nxt   = head.item.area;
      bit_nxt    = '0;
    end else if (step) begin
      if (in_glyph) begin
        left_nxt = left_r - 1'b1;
        if (({1'b0, col_r} + 1'b1) >= {1'b0, width_r}) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      bit_nxt = done ? '0 : bit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= '1;
      bg_r     <= '1;
      base_x_r <= '0;
      base_y_r <= '0;
      width_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
      bit_r    <= '0;
    end else begin
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      width_r  <= width_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
      bit_r    <= bit_nxt;
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FOREGROUND: fg_r <= cfg_data[COLOR_BITS-1:0];
          CFG_BACKGROUND: bg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pgbe_pix_q.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgbe_pix_q
// Result queue: parts the pixel engine from the receiver so that a stalled
// receiver does not hold up the engine at once.
// ----------------------------------------------------------------------------
module pgbe_pix_q
  import pgbe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pix_t pix_in,
  output      logic full,
  input  wire logic pop,
  output      logic empty,
  output      pix_t pix_out
);

  pix_t                    mem_r [PIX_Q_DEPTH];
  logic [PIX_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PIX_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PIX_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    wr_en;
  logic                    rd_en;

  assign full  = (cnt_r == PIX_CNT_BITS'(PIX_Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign pix_out = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: hw/rtl/packed_glyph_bitmap_expander.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_glyph_bitmap_expander
// Expands a packed 1 bpp glyph bitmap into pixel writes.
//
// Input words go in with push while full is low. A begin word (action 0)
// loads origin and size; each byte word (action 1) gives up to eight pixels,
// MSB first, in raster order. Pixel words come out while empty is low and
// are taken with pop. Colors are set through the cfg port (index 0
// foreground, index 1 background, all ones = transparent); cfg_ready is
// always high and writes are meant for an idle block.
// While the result queue has room the engine walks one bitmap bit per cycle:
// a byte word runs to its last bit or stops early when the glyph ends inside
// it; a begin word or a byte past the glyph is taken without walking its bits.
// In an idle block the first pixel of a byte can reach the result queue on
// the next edge after the one that accepts it. With room there, the sustained
// rate is one pixel per cycle, set by the single-bit engine step. When pop
// stays low, the 2-word result queue fills, the engine holds its bit position
// and the 2-word input queue then raises full. Reset empties both queues,
// clears origin, size and counters, and sets both colors to all ones.
// ----------------------------------------------------------------------------
module packed_glyph_bitmap_expander
  import pgbe_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [BG_BITS-1:0]           cfg_data,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic                         in_action,
  input  wire logic signed [COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [COORD_BITS-1:0] in_origin_y,
  input  wire logic [DIM_BITS-1:0]          in_glyph_width,
  input  wire logic [DIM_BITS-1:0]          in_glyph_height,
  input  wire logic [BYTE_BITS-1:0]         in_bitmap_byte,
  output      logic                         empty,
  input  wire logic                         pop,
  output      logic signed [OUTC_BITS-1:0]  out_pixel_x,
  output      logic signed [OUTC_BITS-1:0]  out_pixel_y,
  output      logic [COLOR_BITS-1:0]        out_pixel_color,
  output      logic                         out_glyph_end,
  output      logic                         out_last_of_run
);

  item_head_t head;
  logic       item_pop;
  logic       pix_full;
  logic       pix_push;
  pix_t       pix;
  pix_t       pix_out;

  assign cfg_ready = 1'b1;

  pgbe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_bitmap_byte  (in_bitmap_byte),
    .item_pop        (item_pop),
    .head            (head)
  );

  pgbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .item_pop  (item_pop),
    .pix_full  (pix_full),
    .pix_push  (pix_push),
    .pix       (pix)
  );

  pgbe_pix_q u_pix_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (pix_push),
    .pix_in  (pix),
    .full    (pix_full),
    .pop     (pop),
    .empty   (empty),
    .pix_out (pix_out)
  );

  assign out_pixel_x     = pix_out.x;
  assign out_pixel_y     = pix_out.y;
  assign out_pixel_color = pix_out.color;
  assign out_glyph_end   = pix_out.glyph_end;
  assign out_last_of_run = pix_out.last_of_run;

endmodule
`default_nettype wire

// File: hw/rtl/pgbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgbe_checker
// Port-level checks of the glyph expander, bound to the top level.
// ----------------------------------------------------------------------------
module pgbe_checker
  import pgbe_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        full,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic signed [OUTC_BITS-1:0] out_pixel_x,
  input wire logic signed [OUTC_BITS-1:0] out_pixel_y,
  input wire logic [COLOR_BITS-1:0]       out_pixel_color,
  input wire logic                        out_glyph_end,
  input wire logic                        out_last_of_run
);

  // reset leaves both queues empty
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // the last pixel of a glyph always closes its byte's run
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_glyph_end) |-> out_last_of_run)
    else $error("glyph end without last of run");

  // a waiting pixel word holds while not taken
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_color) && $stable(out_glyph_end)
      && $stable(out_last_of_run)))
    else $error("stalled pixel word changed");

endmodule

bind packed_glyph_bitmap_expander pgbe_checker u_pgbe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_color (out_pixel_color),
  .out_glyph_end   (out_glyph_end),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire

// File: tb/packed_glyph_bitmap_expander_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_glyph_bitmap_expander_tb
// Self-checking bench for the glyph bitmap expander. Begin and bitmap byte
// words go in through the push/full queue port. A scoreboard class expands
// every accepted word into the pixel words it should cause, and checks each
// popped pixel word field by field against the oldest pending one. Colors
// change between phases while the block is idle, from extreme values to
// random ones. Both sides stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
  localparam logic [pgbe_pkg::BG_BITS-1:0] BG_CLEAR = '1;

  logic [pgbe_pkg::COLOR_BITS-1:0] fg_color;
  logic [pgbe_pkg::BG_BITS-1:0]    bg_color;
  logic [pgbe_pkg::COORD_BITS-1:0] base_x;
  logic [pgbe_pkg::COORD_BITS-1:0] base_y;
  logic [7:0]                      width_q;
  logic [7:0]                      height_q;
  logic [7:0]                      col_q;
  logic [8:0]                      row_q;
  pgbe_pkg::pix_t                  pending_pixels[$];
  int                              mismatch_count;

  function new();
    fg_color       = '1;
    bg_color       = BG_CLEAR;
    base_x         = '0;
    base_y         = '0;
    width_q        = '0;
    height_q       = '0;
    col_q          = '0;
    row_q          = '0;
    mismatch_count = 0;
  endfunction

  function void write_reg(input pgbe_pkg::cfg_idx_t idx,
                          input logic [pgbe_pkg::BG_BITS-1:0] data);
    if (idx == pgbe_pkg::CFG_FOREGROUND) begin
      fg_color = data[pgbe_pkg::COLOR_BITS-1:0];
    end else begin
      bg_color = data;
    end
  endfunction

  function void expand_word(input logic action,
                            input logic [pgbe_pkg::COORD_BITS-1:0] ox,
                            input logic [pgbe_pkg::COORD_BITS-1:0] oy,
                            input logic [7:0] w,
                            input logic [7:0] h,
                            input logic [7:0] bits);
    pgbe_pkg::pix_t run[8];
    pgbe_pkg::pix_t px;
    int             n;
    int             i;
    bit             emit;
    if (action == pgbe_pkg::ACT_BEGIN) begin
      base_x   = ox;
      base_y   = oy;
      width_q  = w;
      height_q = h;
      col_q    = '0;
      row_q    = '0;
      return;
    end
    n = 0;
    for (i = 0; i < 8; i++) begin
      if (width_q == 0 || int'(row_q) >= int'(height_q)) break;
      px.x           = {base_x[pgbe_pkg::COORD_BITS-1], base_x} + {9'd0, col_q};
      px.y           = {base_y[pgbe_pkg::COORD_BITS-1], base_y} + {8'd0, row_q};
      px.glyph_end   = (int'(col_q) + 1 == int'(width_q)) &&
                       (int'(row_q) + 1 == int'(height_q));
      px.last_of_run = 1'b0;
      emit           = 1'b1;
      if (bits[7-i]) begin
        px.color = fg_color;
      end else if (bg_color == BG_CLEAR) begin
        px.color = '0;
        emit     = 1'b0;
      end else begin
        px.color = bg_color[pgbe_pkg::COLOR_BITS-1:0];
      end
      if (emit) begin
        run[n] = px;
        n++;
      end
      if (int'(col_q) + 1 >= int'(width_q)) begin
        col_q = '0;
        row_q = row_q + 9'd1;
      end else begin
        col_q = col_q + 8'd1;
      end
    end
    for (i = 0; i < n; i++) begin
      px             = run[i];
      px.last_of_run = (i == n - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  function void check_pixel(input logic signed [pgbe_pkg::OUTC_BITS-1:0] x,
                            input logic signed [pgbe_pkg::OUTC_BITS-1:0] y,
                            input logic [pgbe_pkg::COLOR_BITS-1:0] color,
                            input logic ge,
                            input logic lor);
    pgbe_pkg::pix_t want;
    if (pending_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected pixel word x=%0d y=%0d color=%h end=%b last=%b",
                 x, y, color, ge, lor);
      return;
    end
    want = pending_pixels.pop_front();
    if (want.x !== x || want.y !== y || want.color !== color ||
        want.glyph_end !== ge || want.last_of_run !== lor) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("pixel mismatch: exp x=%0d y=%0d color=%h end=%b last=%b, %s%0d y=%0d %s",
                 want.x, want.y, want.color, want.glyph_end, want.last_of_run,
                 "got x=", x, y, $sformatf("color=%h end=%b last=%b", color, ge, lor));
    end
  endfunction
endclass

module packed_glyph_bitmap_expander_tb;
  import pgbe_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_WORDS   = 73;
  localparam int NUM_PHASES    = 6;

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         cfg_valid       = 1'b0;
  cfg_idx_t                     cfg_index       = CFG_FOREGROUND;
  logic [BG_BITS-1:0]           cfg_data        = '0;
  logic                         push            = 1'b0;
  logic                         in_action       = 1'b0;
  logic signed [COORD_BITS-1:0] in_origin_x     = '0;
  logic signed [COORD_BITS-1:0] in_origin_y     = '0;
  logic [DIM_BITS-1:0]          in_glyph_width  = '0;
  logic [DIM_BITS-1:0]          in_glyph_height = '0;
  logic [BYTE_BITS-1:0]         in_bitmap_byte  = '0;
  logic                         pop             = 1'b0;
  logic                         cfg_ready;
  logic                         full;
  logic                         empty;
  logic signed [OUTC_BITS-1:0]  out_pixel_x;
  logic signed [OUTC_BITS-1:0]  out_pixel_y;
  logic [COLOR_BITS-1:0]        out_pixel_color;
  logic                         out_glyph_end;
  logic                         out_last_of_run;

  pixel_scoreboard sb;
  bit              idle_ok    = 1'b1;
  int              words_sent = 0;

  always #5 clk = ~clk;

  packed_glyph_bitmap_expander u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_bitmap_byte  (in_bitmap_byte),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_glyph_end   (out_glyph_end),
    .out_last_of_run (out_last_of_run)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (push && !full)
        sb.expand_word(in_action, in_origin_x, in_origin_y, in_glyph_width,
                       in_glyph_height, in_bitmap_byte);
      if (pop && !empty)
        sb.check_pixel(out_pixel_x, out_pixel_y, out_pixel_color, out_glyph_end,
                       out_last_of_run);
    end
  end

  // result side stalls
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_ok && $urandom_range(0, 9) == 0) begin
        pop = 1'b0;
        n   = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end else begin
        pop = 1'b1;
      end
    end
  end

  task automatic send_word(input logic action, input logic [COORD_BITS-1:0] ox,
                           input logic [COORD_BITS-1:0] oy, input logic [7:0] w,
                           input logic [7:0] h, input logic [7:0] bits);
    int gap;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      gap  = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    push            = 1'b1;
    in_action       = action;
    in_origin_x     = ox;
    in_origin_y     = oy;
    in_glyph_width  = w;
    in_glyph_height = h;
    in_bitmap_byte  = bits;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_begin(input logic [COORD_BITS-1:0] ox, input logic [COORD_BITS-1:0] oy,
                            input logic [7:0] w, input logic [7:0] h);
    send_word(ACT_BEGIN, ox, oy, w, h, 8'($urandom()));
  endtask

  task automatic send_byte(input logic [7:0] bits);
    send_word(ACT_BYTE, 16'($urandom()), 16'($urandom()), 8'($urandom()), 8'($urandom()),
              bits);
  endtask

  // sender holds off until every pending pixel word is out and the engine is quiet
  task automatic drain();
    int quiet;
    push  = 1'b0;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(negedge clk);
      if (sb.pending_pixels.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [BG_BITS-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_colors(input logic [COLOR_BITS-1:0] fg, input logic [BG_BITS-1:0] bg);
    write_reg(CFG_FOREGROUND, {1'($urandom_range(0, 1)), fg});
    write_reg(CFG_BACKGROUND, bg);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom());
  endfunction

  task automatic random_glyph();
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [7:0]            w;
    logic [7:0]            h;
    int                    pick;
    int                    r;
    int                    area_bytes;
    int                    nbytes;
    int                    k;
    pick = $urandom_range(0, 99);
    ox   = 16'($urandom());
    oy   = 16'($urandom());
    if ($urandom_range(0, 7) == 0) ox = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    if ($urandom_range(0, 7) == 0) oy = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    if (pick < 80) begin
      w = 8'($urandom_range(1, 12));
      h = 8'($urandom_range(1, 10));
    end else if (pick < 88) begin
      w = 8'($urandom());
      h = 8'($urandom());
      if ($urandom_range(0, 1)) w = '0;
      else h = '0;
    end else if (pick < 95) begin
      w = 8'($urandom());
      h = 8'($urandom());
    end else begin
      w = 8'($urandom());
      h = 8'($urandom_range(1, 2));
    end
    area_bytes = (int'(w) * int'(h) + 7) / 8;
    nbytes     = area_bytes;
    if (pick < 80) begin
      r = $urandom_range(0, 9);
      if (r == 0) nbytes = $urandom_range(0, area_bytes);
      else if (r == 1) nbytes = area_bytes + $urandom_range(1, 3);
    end else if (pick < 88) begin
      nbytes = $urandom_range(1, 3);
    end else if (pick < 95) begin
      nbytes = $urandom_range(1, 6);
    end
    send_begin(ox, oy, w, h);
    for (k = 0; k < nbytes; k++) send_byte(pick_byte());
  endtask

  task automatic directed_words();
    send_byte(8'hff);
    send_begin(16'h8000, 16'h7fff, 8'd3, 8'd2);
    send_byte(8'ha5);
    send_byte(8'hff);
    send_begin(16'h7fff, 16'h8000, 8'd1, 8'd1);
    send_byte(8'h80);
    // last pixel clear under a transparent background
    send_begin(16'h0000, 16'h0000, 8'd3, 8'd1);
    send_byte(8'hc0);
    send_begin(16'h0010, 16'h0020, 8'd0, 8'd5);
    send_byte(8'hff);
    send_begin(16'h0010, 16'h0020, 8'd5, 8'd0);
    send_byte(8'hff);
    send_begin(16'h7fff, 16'h7fff, 8'd255, 8'd255);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_begin(16'hfffb, 16'hffff, 8'd4, 8'd4);
    send_byte(8'h0f);
    send_byte(8'hf0);
    send_begin(16'd100, 16'd200, 8'd9, 8'd2);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte(8'hc0);
  endtask

  initial begin
    int p;
    sb = new();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    directed_words();
    drain();
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_colors(16'h0000, 17'h00000);
        1: set_colors(16'hffff, 17'h0ffff);
        2: set_colors(16'($urandom()), 17'h1ffff);
        3: set_colors(16'($urandom()), 17'h10000);
        4: set_colors(16'($urandom()), 17'($urandom()));
        default: begin
          set_colors(16'h5a5a, 17'h1ffff);
          idle_ok = 1'b0;
        end
      endcase
      while (words_sent < 25 + PHASE_WORDS * (p + 1)) begin
        if ($urandom_range(0, 9) == 0)
          send_word(1'($urandom()), 16'($urandom()), 16'($urandom()),
                    8'($urandom()), 8'($urandom()), 8'($urandom()));
        else
          random_glyph();
      end
      drain();
    end
    if (sb.mismatch_count == 0 && sb.pending_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: packed_glyph_bitmap_expander.f
hw/rtl/pgbe_pkg.sv
hw/rtl/pgbe_front.sv
hw/rtl/pgbe_back.sv
hw/rtl/pgbe_pix_q.sv
hw/rtl/packed_glyph_bitmap_expander.sv
hw/rtl/pgbe_checker.sv
tb/packed_glyph_bitmap_expander_tb.sv
